// File: hw/rtl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants of the per-source rate limiter
// Payload structs, operation and state codes, table sizes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package psrl_pkg;
	localparam int COUNTER_ENTRIES = 16;
	localparam int BLOCK_ENTRIES = 16;
	localparam logic [31:0] BLOCK_SECONDS = 32'd86400;
	localparam logic [15:0] MAX_REQUESTS_RESET = 16'd60;
	localparam logic [15:0] WINDOW_SECONDS_RESET = 16'd60;

	typedef enum logic [1:0] {
		OP_CHECK   = 2'd0,
		OP_REPORT  = 2'd1,
		OP_CLEANUP = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	localparam logic CFG_MAX_REQUESTS = 1'b0;
	localparam logic CFG_WINDOW_SECONDS = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] source_address;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic        allowed;
		logic [15:0] request_count;
		logic        over_limit;
		logic        table_full;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE,
		ST_OUT
	} state_t;

	// Command broadcast from sequencer to every cell of one table.
	typedef struct packed {
		logic        clear;     // drop all entries
		logic        wr;        // write the selected entry
		logic        inv;       // invalidate the selected entry
		logic        sweep;     // cleanup test on every entry
		logic [31:0] addr;
		logic [31:0] now;
		logic [15:0] count;
		logic [31:0] start;
		logic [31:0] last;
		logic        seen;
		logic [16:0] limit;
	} cell_cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/psrl_cell.sv
// ----------------------------------------------------------------------------
// psrl_cell: one table entry on a rotating ring
// Holds one entry and passes it to its neighbor every scan cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psrl_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               shift,
	input  wire logic               sel,
	input  wire psrl_pkg::cell_cmd_t cmd,
	input  wire logic               prev_valid,
	input  wire logic [31:0]        prev_addr,
	input  wire logic [15:0]        prev_count,
	input  wire logic [31:0]        prev_start,
	input  wire logic [31:0]        prev_last,
	input  wire logic               prev_seen,
	output logic                    valid_q,
	output logic [31:0]             addr_q,
	output logic [15:0]             count_q,
	output logic [31:0]             start_q,
	output logic [31:0]             last_q,
	output logic                    seen_q
);
	logic drop;
	logic [31:0] age;
	assign age = cmd.now - last_q;
	assign drop = cmd.sweep && valid_q && (!seen_q || (age[31:17] != 15'd0)
		|| age[16:0] > cmd.limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (cmd.clear || drop) begin
			valid_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
			seen_q <= prev_seen;
		end else if (sel && cmd.inv) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.wr) begin
			valid_q <= 1'b1;
			seen_q <= cmd.seen;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			addr_q <= prev_addr;
			count_q <= prev_count;
			start_q <= prev_start;
			last_q <= prev_last;
		end else if (sel && cmd.wr) begin
			addr_q <= cmd.addr;
			count_q <= cmd.count;
			start_q <= cmd.start;
			last_q <= cmd.last;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/psrl_ring.sv
// ----------------------------------------------------------------------------
// psrl_ring: a ring of cells forming one table
// Shifting rotates all entries by one; cell 0 is the inspection point.
// ----------------------------------------------------------------------------
`default_nettype none
module psrl_ring #(
	parameter int ENTRIES = psrl_pkg::COUNTER_ENTRIES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               shift,
	input  wire logic [ENTRIES-1:0] sel,
	input  wire psrl_pkg::cell_cmd_t cmd,
	output logic                    head_valid,
	output logic [31:0]             head_addr,
	output logic [15:0]             head_count,
	output logic [31:0]             head_start,
	output logic [31:0]             head_last,
	output logic                    head_seen
);
	logic        v [ENTRIES];
	logic [31:0] a [ENTRIES];
	logic [15:0] c [ENTRIES];
	logic [31:0] s [ENTRIES];
	logic [31:0] l [ENTRIES];
	logic        n [ENTRIES];

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		localparam int P = (g + 1) % ENTRIES;
		psrl_cell u_cell (
			.clk, .arst_n, .shift,
			.sel(sel[g]),
			.cmd,
			.prev_valid(v[P]), .prev_addr(a[P]), .prev_count(c[P]),
			.prev_start(s[P]), .prev_last(l[P]), .prev_seen(n[P]),
			.valid_q(v[g]), .addr_q(a[g]), .count_q(c[g]),
			.start_q(s[g]), .last_q(l[g]), .seen_q(n[g])
		);
	end

	assign head_valid = v[0];
	assign head_addr = a[0];
	assign head_count = c[0];
	assign head_start = s[0];
	assign head_last = l[0];
	assign head_seen = n[0];
endmodule
`default_nettype wire

// File: hw/rtl/per_source_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_rate_limiter: per-source fixed-window limiter with block list
// Counter and block tables are rings of cells scanned by one sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time. Each table is a ring of cells that rotates one
// entry per cycle past a head cell; both rings rotate together, and a full
// pass of ENTRIES shifts returns every entry to its slot, so slot order is
// kept and "lowest free slot" is the first free entry met. After the pass a
// one-hot slot select writes the chosen entry in place and cleanup tests all
// counters at once. The rings rotate in ST_SCAN, the result is registered in
// ST_DONE and offered in ST_OUT. A result waits in an output register and the
// input stays closed until it leaves.
`default_nettype none
module per_source_rate_limiter #(
	parameter int COUNTER_ENTRIES = psrl_pkg::COUNTER_ENTRIES,
	parameter int BLOCK_ENTRIES = psrl_pkg::BLOCK_ENTRIES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire psrl_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output psrl_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [15:0]         cfg_data
);
	psrl_pkg::state_t state_q, state_d;
	psrl_pkg::in_item_t item_q;
	psrl_pkg::out_item_t res;
	logic [15:0] max_q, win_q;
	logic [COUNTER_ENTRIES-1:0] ctok_q, chit_q, cfree_q, csel;
	logic [BLOCK_ENTRIES-1:0] btok_q, bhit_q, bfree_q, bsel;
	logic cact_q, bact_q;
	logic cfound_q, cfree_ok_q, bfound_q, bfree_ok_q, blocked_q;
	logic [15:0] ccount_q;
	logic [31:0] cstart_q, clast_q;
	logic cseen_q;

	logic cshift, bshift;
	psrl_pkg::cell_cmd_t ccmd, bcmd;
	logic ch_v, ch_n, bh_v;
	logic [31:0] ch_a, ch_s, ch_l, bh_a, bh_s;
	logic [15:0] ch_c;

	psrl_ring #(.ENTRIES(COUNTER_ENTRIES)) u_cring (
		.clk, .arst_n, .shift(cshift), .sel(csel), .cmd(ccmd),
		.head_valid(ch_v), .head_addr(ch_a), .head_count(ch_c),
		.head_start(ch_s), .head_last(ch_l), .head_seen(ch_n)
	);
	psrl_ring #(.ENTRIES(BLOCK_ENTRIES)) u_bring (
		.clk, .arst_n, .shift(bshift), .sel(bsel), .cmd(bcmd),
		.head_valid(bh_v), .head_addr(bh_a), .head_count(),
		.head_start(bh_s), .head_last(), .head_seen()
	);

	logic [1:0] op;
	logic [31:0] now;
	logic chit_now, bhit_now, cscan, bscan, scan_end, done;
	assign op = item_q.operation;
	assign now = item_q.now_seconds;
	assign chit_now = ch_v && (ch_a == item_q.source_address);
	assign bhit_now = bh_v && (bh_a == item_q.source_address);
	assign cscan = (state_q == psrl_pkg::ST_SCAN) && cact_q;
	assign bscan = (state_q == psrl_pkg::ST_SCAN) && bact_q;
	assign scan_end = (!cact_q || ctok_q[COUNTER_ENTRIES-1])
		&& (!bact_q || btok_q[BLOCK_ENTRIES-1]);
	assign done = (state_q == psrl_pkg::ST_DONE);

	// decisions from the scan results, used in ST_DONE
	logic [31:0] start0, wage, start1, last1;
	logic [15:0] count0, c_base, c_new;
	logic restart, c_admit, c_use, seen1, rep_hit, b_store;
	logic [18:0] five_c, four_m;
	always_comb begin
		start0 = cfound_q ? cstart_q : now;
		count0 = cfound_q ? ccount_q : 16'd0;
		wage = now - start0;
		restart = wage >= {16'd0, win_q};
		c_base = restart ? 16'd0 : count0;
		start1 = restart ? now : start0;
		c_admit = c_base < max_q;
		c_new = c_admit ? c_base + 16'd1 : c_base;
		last1 = c_admit ? now : (cfound_q ? clast_q : 32'd0);
		seen1 = c_admit || (cfound_q && cseen_q);
		c_use = cfound_q || cfree_ok_q;
		five_c = {3'd0, count0} + {1'b0, count0, 2'b00};
		four_m = {1'b0, max_q, 2'b00};
		rep_hit = five_c > four_m;
		b_store = bfound_q || bfree_ok_q;
	end

	always_comb begin
		res = '0;
		case (op)
			psrl_pkg::OP_CHECK: begin
				if (blocked_q) begin
					res.request_count = count0;
				end else if (!c_use) begin
					res.table_full = 1'b1;
				end else begin
					res.allowed = c_admit;
					res.request_count = c_new;
				end
			end
			psrl_pkg::OP_REPORT: begin
				res.request_count = count0;
				res.table_full = rep_hit && !b_store;
			end
			psrl_pkg::OP_QUERY: begin
				res.request_count = count0;
				res.over_limit = cfound_q && (ccount_q >= max_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			psrl_pkg::ST_IDLE: if (in_valid) state_d = psrl_pkg::ST_SCAN;
			psrl_pkg::ST_SCAN: if (scan_end) state_d = psrl_pkg::ST_DONE;
			psrl_pkg::ST_DONE: state_d = psrl_pkg::ST_OUT;
			psrl_pkg::ST_OUT:  if (out_ready) state_d = psrl_pkg::ST_IDLE;
			default:           state_d = psrl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == psrl_pkg::ST_IDLE);
		out_valid = (state_q == psrl_pkg::ST_OUT);
	end

	always_comb begin
		cshift = cscan;
		bshift = bscan;
		ccmd = '0;
		bcmd = '0;
		ccmd.clear = cfg_we;
		ccmd.sweep = done && (op == psrl_pkg::OP_CLEANUP);
		ccmd.now = now;
		ccmd.limit = {win_q, 1'b0};
		ccmd.addr = item_q.source_address;
		ccmd.count = c_new;
		ccmd.start = start1;
		ccmd.last = last1;
		ccmd.seen = seen1;
		ccmd.wr = done && (op == psrl_pkg::OP_CHECK) && !blocked_q && c_use;
		csel = cfound_q ? chit_q : cfree_q;
		bcmd.now = now;
		bcmd.addr = item_q.source_address;
		bcmd.start = now;
		bcmd.inv = done && (op == psrl_pkg::OP_CHECK) && bfound_q && !blocked_q;
		bcmd.wr = done && (op == psrl_pkg::OP_REPORT) && rep_hit && b_store;
		bsel = ((op == psrl_pkg::OP_REPORT) && !bfound_q) ? bfree_q : bhit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psrl_pkg::ST_IDLE;
			max_q <= psrl_pkg::MAX_REQUESTS_RESET;
			win_q <= psrl_pkg::WINDOW_SECONDS_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == psrl_pkg::CFG_MAX_REQUESTS) max_q <= cfg_data;
			if (cfg_we && cfg_index == psrl_pkg::CFG_WINDOW_SECONDS) win_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
			ctok_q <= COUNTER_ENTRIES'(1);
			btok_q <= BLOCK_ENTRIES'(1);
			cact_q <= 1'b1;
			bact_q <= 1'b1;
			cfound_q <= 1'b0;
			cfree_ok_q <= 1'b0;
			bfound_q <= 1'b0;
			bfree_ok_q <= 1'b0;
			blocked_q <= 1'b0;
		end
		if (cscan) begin
			ctok_q <= ctok_q << 1;
			if (ctok_q[COUNTER_ENTRIES-1]) cact_q <= 1'b0;
			if (chit_now && !cfound_q) begin
				cfound_q <= 1'b1;
				chit_q <= ctok_q;
				ccount_q <= ch_c;
				cstart_q <= ch_s;
				clast_q <= ch_l;
				cseen_q <= ch_n;
			end
			if (!ch_v && !cfree_ok_q) begin
				cfree_ok_q <= 1'b1;
				cfree_q <= ctok_q;
			end
		end
		if (bscan) begin
			btok_q <= btok_q << 1;
			if (btok_q[BLOCK_ENTRIES-1]) bact_q <= 1'b0;
			if (bhit_now && !bfound_q) begin
				bfound_q <= 1'b1;
				bhit_q <= btok_q;
				blocked_q <= (now - bh_s) < psrl_pkg::BLOCK_SECONDS;
			end
			if (!bh_v && !bfree_ok_q) begin
				bfree_ok_q <= 1'b1;
				bfree_q <= btok_q;
			end
		end
		if (done) out_data <= res;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data));
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid));
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready);
endmodule
`default_nettype wire

// File: dv/tb_per_source_rate_limiter.sv
// ----------------------------------------------------------------------------
// tb_per_source_rate_limiter: self-checking bench of the per-source limiter
// Drives check, report, cleanup and query transactions through valid/ready,
// predicts every result from a behavioral copy of both tables and compares
// each field in a scoreboard class. Idling, back-pressure and config phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_per_source_rate_limiter;
	localparam int LIMIT_IDLE = 20000;

	class limiter_scoreboard;
		logic [15:0] max_req;
		logic [15:0] win_sec;
		bit          c_valid [psrl_pkg::COUNTER_ENTRIES];
		logic [31:0] c_addr [psrl_pkg::COUNTER_ENTRIES];
		logic [15:0] c_req [psrl_pkg::COUNTER_ENTRIES];
		logic [31:0] c_wstart [psrl_pkg::COUNTER_ENTRIES];
		logic [31:0] c_seen [psrl_pkg::COUNTER_ENTRIES];
		bit          c_seen_set [psrl_pkg::COUNTER_ENTRIES];
		bit          b_valid [psrl_pkg::BLOCK_ENTRIES];
		logic [31:0] b_addr [psrl_pkg::BLOCK_ENTRIES];
		logic [31:0] b_start [psrl_pkg::BLOCK_ENTRIES];
		psrl_pkg::out_item_t pending [$];
		int          errors;

		function void init();
			max_req = psrl_pkg::MAX_REQUESTS_RESET;
			win_sec = psrl_pkg::WINDOW_SECONDS_RESET;
			foreach (c_valid[i]) begin
				c_valid[i] = 0;
				c_seen_set[i] = 0;
			end
			foreach (b_valid[i])
				b_valid[i] = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == psrl_pkg::CFG_MAX_REQUESTS)
				max_req = val;
			else
				win_sec = val;
			foreach (c_valid[i]) begin
				c_valid[i] = 0;
				c_seen_set[i] = 0;
			end
		endfunction

		function int find_ctr(logic [31:0] a);
			for (int i = 0; i < psrl_pkg::COUNTER_ENTRIES; i++)
				if (c_valid[i] && c_addr[i] == a)
					return i;
			return -1;
		endfunction

		function int find_blk(logic [31:0] a);
			for (int i = 0; i < psrl_pkg::BLOCK_ENTRIES; i++)
				if (b_valid[i] && b_addr[i] == a)
					return i;
			return -1;
		endfunction

		function void note_input(psrl_pkg::in_item_t it);
			psrl_pkg::out_item_t r;
			int c;
			int b;
			bit blocked;
			logic [31:0] age;
			logic [16:0] lim;
			r = '0;
			c = find_ctr(it.source_address);
			case (psrl_pkg::op_t'(it.operation))
				psrl_pkg::OP_CHECK: begin
					blocked = 0;
					b = find_blk(it.source_address);
					if (b >= 0) begin
						age = it.now_seconds - b_start[b];
						if (age < psrl_pkg::BLOCK_SECONDS)
							blocked = 1;
						else
							b_valid[b] = 0;
					end
					if (blocked) begin
						if (c >= 0)
							r.request_count = c_req[c];
					end else begin
						if (c < 0) begin
							for (int i = 0; i < psrl_pkg::COUNTER_ENTRIES; i++)
								if (!c_valid[i]) begin
									c = i;
									break;
								end
							if (c >= 0) begin
								c_valid[c] = 1;
								c_addr[c] = it.source_address;
								c_req[c] = 0;
								c_wstart[c] = it.now_seconds;
								c_seen_set[c] = 0;
							end
						end
						if (c < 0) begin
							r.table_full = 1;
						end else begin
							age = it.now_seconds - c_wstart[c];
							if (age >= {16'd0, win_sec}) begin
								c_req[c] = 0;
								c_wstart[c] = it.now_seconds;
							end
							if (c_req[c] < max_req) begin
								c_req[c] = c_req[c] + 16'd1;
								c_seen[c] = it.now_seconds;
								c_seen_set[c] = 1;
								r.allowed = 1;
							end
							r.request_count = c_req[c];
						end
					end
				end
				psrl_pkg::OP_REPORT: begin
					if (c >= 0)
						r.request_count = c_req[c];
					if (5 * int'(r.request_count) > 4 * int'(max_req)) begin
						b = find_blk(it.source_address);
						if (b < 0)
							for (int i = 0; i < psrl_pkg::BLOCK_ENTRIES; i++)
								if (!b_valid[i]) begin
									b = i;
									break;
								end
						if (b < 0) begin
							r.table_full = 1;
						end else begin
							b_valid[b] = 1;
							b_addr[b] = it.source_address;
							b_start[b] = it.now_seconds;
						end
					end
				end
				psrl_pkg::OP_CLEANUP: begin
					lim = {win_sec, 1'b0};
					for (int i = 0; i < psrl_pkg::COUNTER_ENTRIES; i++) begin
						age = it.now_seconds - c_seen[i];
						if (c_valid[i] && (!c_seen_set[i] || age > {15'd0, lim})) begin
							c_valid[i] = 0;
							c_seen_set[i] = 0;
						end
					end
				end
				default: begin
					if (c >= 0) begin
						r.request_count = c_req[c];
						r.over_limit = c_req[c] >= max_req;
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(psrl_pkg::out_item_t got);
			psrl_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.allowed !== e.allowed) begin
				$error("allowed: expected %0d actual %0d", e.allowed, got.allowed);
				errors++;
			end
			if (got.request_count !== e.request_count) begin
				$error("request_count: expected %0d actual %0d",
					e.request_count, got.request_count);
				errors++;
			end
			if (got.over_limit !== e.over_limit) begin
				$error("over_limit: expected %0d actual %0d", e.over_limit, got.over_limit);
				errors++;
			end
			if (got.table_full !== e.table_full) begin
				$error("table_full: expected %0d actual %0d", e.table_full, got.table_full);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	psrl_pkg::in_item_t  in_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	psrl_pkg::out_item_t out_data;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [15:0] cfg_data = '0;

	limiter_scoreboard sb;
	bit          idle_off = 0;
	bit          hold_rx = 0;
	int          quiet = 0;
	logic [31:0] clock_s = 0;
	logic [31:0] pool [8];

	always #10 clk = ~clk;

	per_source_rate_limiter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_input(in_data);
		if (out_valid && out_ready)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > LIMIT_IDLE) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_rx)
			out_ready <= 0;
		else if (idle_off)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(99) >= 16);
	end

	// valid stays up after the accepting edge; the next send replaces the item or drain drops it
	task automatic send(logic [1:0] op, logic [31:0] addr, logic [31:0] now);
		while (!idle_off && $urandom_range(99) < 16) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{operation: op, source_address: addr, now_seconds: now};
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int n);
		logic [1:0] op;
		logic [31:0] addr;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			op = (r < 60) ? psrl_pkg::OP_CHECK : (r < 75) ? psrl_pkg::OP_REPORT :
				(r < 85) ? psrl_pkg::OP_CLEANUP : psrl_pkg::OP_QUERY;
			addr = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(7)];
			r = $urandom_range(99);
			if (r < 70)
				clock_s = clock_s + $urandom_range(3);
			else if (r < 90)
				clock_s = clock_s + $urandom_range(200);
			else if (r < 97)
				clock_s = clock_s + $urandom_range(100000);
			else
				clock_s = clock_s + $urandom;
			send(op, addr, clock_s);
		end
	endtask

	initial begin
		sb = new();
		sb.init();
		foreach (pool[i])
			pool[i] = $urandom;
		repeat (6)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send(psrl_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0);
		send(psrl_pkg::OP_CHECK, 32'h0000_0000, 32'hFFFF_FFF0);
		send(psrl_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		send(psrl_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd5);
		send(psrl_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd5);
		send(psrl_pkg::OP_REPORT, 32'hFFFF_FFFF, 32'd6);
		send(psrl_pkg::OP_CLEANUP, 32'd0, 32'd7);
		write_reg(psrl_pkg::CFG_MAX_REQUESTS, 16'd2);
		write_reg(psrl_pkg::CFG_WINDOW_SECONDS, 16'd10);
		for (int i = 0; i < 3; i++)
			send(psrl_pkg::OP_CHECK, 32'h0A00_0001, 32'd100);
		send(psrl_pkg::OP_QUERY, 32'h0A00_0001, 32'd100);
		send(psrl_pkg::OP_REPORT, 32'h0A00_0001, 32'd101);
		send(psrl_pkg::OP_CHECK, 32'h0A00_0001, 32'd200);
		send(psrl_pkg::OP_CHECK, 32'h0A00_0001, 32'd86501);
		send(psrl_pkg::OP_CHECK, 32'h0A00_0001, 32'd86511);
		for (int i = 0; i < 17; i++)
			send(psrl_pkg::OP_CHECK, 32'hC000_0000 + i, 32'd90000);
		send(psrl_pkg::OP_CLEANUP, 32'd0, 32'd90021);
		send(psrl_pkg::OP_CLEANUP, 32'd0, 32'd90000);

		// block table fill
		write_reg(psrl_pkg::CFG_MAX_REQUESTS, 16'd0);
		for (int i = 0; i < 17; i++) begin
			send(psrl_pkg::OP_CHECK, 32'hB000_0000 + i, 32'd100000);
			send(psrl_pkg::OP_REPORT, 32'hB000_0000 + i, 32'd100000);
		end
		write_reg(psrl_pkg::CFG_MAX_REQUESTS, 16'd1);
		for (int i = 0; i < 17; i++) begin
			send(psrl_pkg::OP_CHECK, 32'hD000_0000 + i, 32'd100001);
			send(psrl_pkg::OP_REPORT, 32'hD000_0000 + i, 32'd100001);
		end

		// window extremes and back-pressure
		write_reg(psrl_pkg::CFG_WINDOW_SECONDS, 16'd0);
		clock_s = 32'd200000;
		hold_rx = 1;
		fork
			random_phase(40);
			begin
				repeat (400)
					@(posedge clk);
				hold_rx = 0;
			end
		join
		write_reg(psrl_pkg::CFG_WINDOW_SECONDS, 16'hFFFF);
		write_reg(psrl_pkg::CFG_MAX_REQUESTS, 16'hFFFF);
		random_phase(100);
		write_reg(psrl_pkg::CFG_MAX_REQUESTS, 16'd5);
		write_reg(psrl_pkg::CFG_WINDOW_SECONDS, 16'd1);
		random_phase(150);
		drain();
		write_reg(psrl_pkg::CFG_WINDOW_SECONDS, 16'd30);
		idle_off = 1;
		random_phase(150);
		idle_off = 0;
		write_reg(psrl_pkg::CFG_MAX_REQUESTS, 16'd3);
		random_phase(250);

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
